// ===== sv/spfm_pkg.sv =====
// Shared types, microcode ROM and byte helpers for the sensor packet framer.
// No dependencies; imported by sensor_packet_framer_manchester_top.
`default_nettype none

package spfm_pkg;

	localparam int unsigned PktLen  = 13;
	localparam int unsigned StepW   = 4;

	localparam logic [7:0] PreambleByte = 8'hFF;
	localparam logic [7:0] SyncIdByte   = 8'hAF;
	localparam logic [7:0] IdByte       = 8'h82;
	localparam logic [3:0] ChanHiNib    = 4'h4;
	localparam logic [7:0] BattFlag     = 8'h80;

	localparam logic [StepW-1:0] LastStep = StepW'(PktLen - 1);

	typedef enum logic [1:0] {
		CFG_CHANNEL  = 2'd0,
		CFG_ROLLING  = 2'd1,
		CFG_POLY     = 2'd2
	} cfg_idx_t;

	// byte source select
	typedef enum logic [3:0] {
		SRC_PRE,
		SRC_SYNC,
		SRC_ID,
		SRC_CHAN,
		SRC_ROLL,
		SRC_TLO,
		SRC_THI,
		SRC_SIGN,
		SRC_LTENS,
		SRC_SUM,
		SRC_CRC
	} src_t;

	// checksum / CRC accumulate mode
	typedef enum logic [1:0] {
		ACC_NONE,
		ACC_INIT,
		ACC_FULL
	} acc_t;

	// digit-extraction micro-op
	typedef enum logic [2:0] {
		CALC_NONE,
		CALC_A,   // hundreds of temp, level tens
		CALC_B,   // temp remainder mod 100, level units
		CALC_C,   // temp tens
		CALC_D    // temp units
	} calc_t;

	typedef struct packed {
		src_t  src;
		acc_t  acc;
		calc_t calc;
		logic  jmp_idle;
	} ucode_t;

	function automatic ucode_t ucode_rom(input logic [StepW-1:0] step);
		ucode_t w;
		w = '{src: SRC_PRE, acc: ACC_NONE, calc: CALC_NONE, jmp_idle: 1'b1};
		case (step)
			4'd0:  w = '{SRC_PRE,   ACC_NONE, CALC_A,    1'b0};
			4'd1:  w = '{SRC_PRE,   ACC_NONE, CALC_B,    1'b0};
			4'd2:  w = '{SRC_PRE,   ACC_NONE, CALC_C,    1'b0};
			4'd3:  w = '{SRC_SYNC,  ACC_INIT, CALC_D,    1'b0};
			4'd4:  w = '{SRC_ID,    ACC_FULL, CALC_NONE, 1'b0};
			4'd5:  w = '{SRC_CHAN,  ACC_FULL, CALC_NONE, 1'b0};
			4'd6:  w = '{SRC_ROLL,  ACC_FULL, CALC_NONE, 1'b0};
			4'd7:  w = '{SRC_TLO,   ACC_FULL, CALC_NONE, 1'b0};
			4'd8:  w = '{SRC_THI,   ACC_FULL, CALC_NONE, 1'b0};
			4'd9:  w = '{SRC_SIGN,  ACC_FULL, CALC_NONE, 1'b0};
			4'd10: w = '{SRC_LTENS, ACC_FULL, CALC_NONE, 1'b0};
			4'd11: w = '{SRC_SUM,   ACC_NONE, CALC_NONE, 1'b0};
			4'd12: w = '{SRC_CRC,   ACC_NONE, CALC_NONE, 1'b1};
			default: w = '{SRC_PRE, ACC_NONE, CALC_NONE, 1'b1};
		endcase
		return w;
	endfunction

	function automatic logic [7:0] swap_nib(input logic [7:0] v);
		return {v[3:0], v[7:4]};
	endfunction

	// one byte through the CRC-8, MSB first
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] m,
		input logic [7:0] poly);
		logic [7:0] c;
		c = crc ^ m;
		for (int k = 0; k < 8; k++) begin
			c = c[7] ? ({c[6:0], 1'b0} ^ poly) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

	// bit order 4,5,6,7,0,1,2,3; one = 10, zero = 01; first chip in bit 15
	function automatic logic [15:0] manchester(input logic [7:0] b);
		logic [15:0] ch;
		logic [7:0]  ord;
		ord = {b[3:0], b[7:4]};
		ch  = '0;
		for (int k = 0; k < 8; k++) begin
			ch[15 - 2*k -: 2] = ord[k] ? 2'b10 : 2'b01;
		end
		return ch;
	endfunction

endpackage

`default_nettype wire

// ===== sv/sensor_packet_framer_manchester_top.sv =====
// Sensor packet framer: one reading in, 13 packet words out with Manchester chips.
// Depends on spfm_pkg (microcode ROM, control word type, CRC and chip helpers).
//
// Channel | Direction | Handshake            | Payload
// --------+-----------+----------------------+-----------------------------------------
// in      | input     | in_valid / in_ready  | temp_tenths[10:0] signed, level[6:0]
// out     | output    | out_valid / out_ready| packet_byte, byte_index, chips, last
// cfg     | input     | cfg_we (no wait)     | cfg_index[1:0], cfg_data[7:0]
//
// With no stalls a reading takes the accept cycle, then the 13-step
// microcode program, one ROM word and one packet word per step.
// The accept cycle sets busy; the first word then enters the output register at step zero.
// Output stalls freeze the step counter; a new reading is taken as soon as the
// last word of the previous one sits in the output register.
// Reset (arst_n low) clears the sequencer and output valid and sets channel 1, code 0, poly 7.
`default_nettype none

module sensor_packet_framer_manchester_top
	import spfm_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output      logic               in_ready,
	input  wire logic signed [10:0] temp_tenths,
	input  wire logic        [6:0]  level,
	output      logic               out_valid,
	input  wire logic               out_ready,
	output      logic        [7:0]  packet_byte,
	output      logic        [3:0]  byte_index,
	output      logic        [15:0] chips,
	output      logic               last_of_packet,
	input  wire logic               cfg_we,
	input  wire logic        [1:0]  cfg_index,
	input  wire logic        [7:0]  cfg_data
);

	// config registers
	logic [3:0] channel_q;
	logic [7:0] rolling_q;
	logic [7:0] poly_q;

	// sequencer
	logic             busy_q;
	logic [StepW-1:0] step_q;
	ucode_t           uw;
	logic             advance;

	// latched reading and digits
	logic [9:0] mag_q;
	logic       neg_q;
	logic [6:0] lvl_q;
	logic [3:0] hund_q;
	logic [6:0] rem_q;
	logic [3:0] ttens_q;
	logic [3:0] tunits_q;
	logic [3:0] ltens_q;
	logic [3:0] lunits_q;

	// running checksum and CRC
	logic [7:0] sum_q;
	logic [7:0] crc_q;

	// output register
	logic        ovalid_q;
	logic [7:0]  obyte_q;
	logic [3:0]  oidx_q;
	logic [15:0] ochips_q;
	logic        olast_q;

	logic               in_fire;
	logic signed [10:0] t_sat;
	logic [10:0]        t_abs;
	logic [6:0]         lvl_sat;
	logic [15:0]        prod_h;
	logic [9:0]         hund_x100;
	logic [9:0]         rem_w;
	logic [14:0]        prod_tt;
	logic [6:0]         ttens_x10;
	logic [6:0]         tunits_w;
	logic [14:0]        prod_lt;
	logic [6:0]         ltens_x10;
	logic [6:0]         lunits_w;
	logic [7:0]         byte_d;

	assign in_ready = !busy_q;
	assign in_fire  = in_valid && in_ready;
	assign uw       = ucode_rom(step_q);
	assign advance  = busy_q && (!ovalid_q || out_ready);

	// saturate the reading on the way in
	always_comb begin
		if (temp_tenths > 11'sd999) begin
			t_sat = 11'sd999;
		end else if (temp_tenths < -11'sd999) begin
			t_sat = -11'sd999;
		end else begin
			t_sat = temp_tenths;
		end
		t_abs   = t_sat[10] ? 11'(-t_sat) : 11'(t_sat);
		lvl_sat = (level > 7'd100) ? 7'd100 : level;
	end

	// digit extraction by reciprocal multiply; exact over the clamped ranges
	always_comb begin
		prod_h    = {6'd0, mag_q} * 16'd41;
		hund_x100 = {6'd0, hund_q} * 10'd100;
		rem_w     = mag_q - hund_x100;
		prod_tt   = {8'd0, rem_q} * 15'd205;
		ttens_x10 = {3'd0, ttens_q} * 7'd10;
		tunits_w  = rem_q - ttens_x10;
		prod_lt   = {8'd0, lvl_q} * 15'd205;
		ltens_x10 = {3'd0, ltens_q} * 7'd10;
		lunits_w  = lvl_q - ltens_x10;
	end

	// byte source mux driven by the control word
	always_comb begin
		case (uw.src)
			SRC_PRE:   byte_d = PreambleByte;
			SRC_SYNC:  byte_d = SyncIdByte;
			SRC_ID:    byte_d = IdByte;
			SRC_CHAN:  byte_d = {ChanHiNib, channel_q};
			SRC_ROLL:  byte_d = swap_nib(rolling_q);
			SRC_TLO:   byte_d = BattFlag | {4'd0, tunits_q};
			SRC_THI:   byte_d = {ttens_q, hund_q};
			SRC_SIGN:  byte_d = {neg_q, 3'd0, lunits_q};
			SRC_LTENS: byte_d = {ltens_q, 4'd0};
			SRC_SUM:   byte_d = swap_nib(sum_q);
			SRC_CRC:   byte_d = swap_nib(crc_q);
			default:   byte_d = PreambleByte;
		endcase
	end

	// config writes; index 3 has no register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_q <= 4'd1;
			rolling_q <= 8'd0;
			poly_q    <= 8'd7;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_CHANNEL: channel_q <= cfg_data[3:0];
				CFG_ROLLING: rolling_q <= cfg_data;
				CFG_POLY:    poly_q    <= cfg_data;
				default:     ;
			endcase
		end
	end

	// step counter with jump back to idle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (in_fire) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (advance) begin
			if (uw.jmp_idle) begin
				busy_q <= 1'b0;
				step_q <= '0;
			end else begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	// datapath: latch reading, digit micro-ops, accumulators
	always_ff @(posedge clk) begin
		if (in_fire) begin
			mag_q <= t_abs[9:0];
			neg_q <= t_sat[10];
			lvl_q <= lvl_sat;
		end
		if (advance) begin
			case (uw.calc)
				CALC_A: begin
					hund_q  <= prod_h[15:12];
					ltens_q <= prod_lt[14:11];
				end
				CALC_B: begin
					rem_q    <= rem_w[6:0];
					lunits_q <= lunits_w[3:0];
				end
				CALC_C:  ttens_q  <= prod_tt[14:11];
				CALC_D:  tunits_q <= tunits_w[3:0];
				default: ;
			endcase
			case (uw.acc)
				ACC_INIT: begin
					sum_q <= {4'd0, byte_d[3:0]};
					crc_q <= crc8_byte(8'd0, {4'd0, byte_d[3:0]}, poly_q);
				end
				ACC_FULL: begin
					sum_q <= sum_q + {4'd0, byte_d[3:0]} + {4'd0, byte_d[7:4]};
					crc_q <= crc8_byte(crc_q, byte_d, poly_q);
				end
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (advance) begin
			ovalid_q <= 1'b1;
		end else if (out_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			obyte_q  <= byte_d;
			oidx_q   <= step_q;
			ochips_q <= manchester(byte_d);
			olast_q  <= uw.jmp_idle;
		end
	end

	assign out_valid      = ovalid_q;
	assign packet_byte    = obyte_q;
	assign byte_index     = oidx_q;
	assign chips          = ochips_q;
	assign last_of_packet = olast_q;

	// the program never runs past the last byte
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> step_q <= LastStep)
		else $error("step counter past last byte");

	// last flag marks exactly the final word
	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q |-> (olast_q == (oidx_q == LastStep)))
		else $error("last flag on wrong word");

	// an accepted reading starts the program at step zero
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> busy_q && step_q == '0)
		else $error("program did not start");

	// emitting the last word returns the sequencer to idle
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		advance && uw.jmp_idle |=> !busy_q && ovalid_q && olast_q)
		else $error("program did not end after last word");

endmodule

`default_nettype wire

// ===== dv/sensor_packet_framer_manchester_top_test.sv =====
// Self-checking testbench for sensor_packet_framer_manchester_top: readings in, packet words out.
// Depends on spfm_pkg for register index names; prediction is built here from scratch.
`timescale 1ns / 1ps

module sensor_packet_framer_manchester_top_test;
	import spfm_pkg::*;

	// index past the register list, writes there must be dropped
	localparam logic [1:0] CfgSpare = 2'd3;

	localparam int WordsPerPacket = 13;
	localparam int RandomPhases   = 8;
	localparam int PhaseReadings  = 50;
	localparam int MaxGap         = 5;
	localparam int SettleCycles   = 20;

	// ------------------------------------------------------------------
	// clock, reset, DUT signals; every input has a known value at time 0
	// ------------------------------------------------------------------
	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic               in_valid = 1'b0;
	logic               in_ready;
	logic signed [10:0] temp_tenths = '0;
	logic        [6:0]  level = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic        [7:0]  packet_byte;
	logic        [3:0]  byte_index;
	logic        [15:0] chips;
	logic               last_of_packet;
	logic               cfg_we = 1'b0;
	logic        [1:0]  cfg_index = '0;
	logic        [7:0]  cfg_data = '0;

	always #5 clk = ~clk;

	sensor_packet_framer_manchester_top i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.temp_tenths    (temp_tenths),
		.level          (level),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.packet_byte    (packet_byte),
		.byte_index     (byte_index),
		.chips          (chips),
		.last_of_packet (last_of_packet),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	// one expected output word
	typedef struct {
		logic [7:0]  pbyte;
		logic [3:0]  idx;
		logic [15:0] chips;
		logic        last;
	} word_t;

	// ------------------------------------------------------------------
	// scoreboard: keeps its own copy of the registers, builds the whole
	// packet for each accepted reading and checks words in order
	// ------------------------------------------------------------------
	class packet_scoreboard;
		word_t      pending_words[$];
		logic [3:0] channel;
		logic [7:0] rolling_code;
		logic [7:0] crc_poly;
		int         errors;
		int         words_checked;

		function new();
			channel       = 4'd1;
			rolling_code  = 8'h00;
			crc_poly      = 8'h07;
			errors        = 0;
			words_checked = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [7:0] data);
			case (idx)
				CFG_CHANNEL: channel = data[3:0];
				CFG_ROLLING: rolling_code = data;
				CFG_POLY:    crc_poly = data;
				default: ;
			endcase
		endfunction

		function int pending();
			return pending_words.size();
		endfunction

		// CRC-8, MSB first
		function logic [7:0] crc_step(logic [7:0] crc, logic [7:0] m);
			logic [7:0] c;
			logic       carry;
			c = crc ^ m;
			for (int k = 0; k < 8; k++) begin
				carry = c[7];
				c = c << 1;
				if (carry)
					c = c ^ crc_poly;
			end
			return c;
		endfunction

		// high nibble goes out first, LSB first within nibble; one = 10, zero = 01
		function logic [15:0] chip_pattern(logic [7:0] b);
			logic [15:0] acc;
			acc = '0;
			for (int k = 0; k < 8; k++)
				acc = {acc[13:0], b[(k + 4) % 8] ? 2'b10 : 2'b01};
			return acc;
		endfunction

		function void note_reading(logic signed [10:0] t, logic [6:0] l);
			int         tv;
			int         lv;
			int         mag;
			bit         neg;
			logic [7:0] pkt [WordsPerPacket];
			logic [7:0] sum;
			logic [7:0] crc;
			word_t      w;
			tv = t;
			lv = l;
			if (tv > 999)
				tv = 999;
			if (tv < -999)
				tv = -999;
			if (lv > 100)
				lv = 100;
			neg = tv < 0;
			mag = neg ? -tv : tv;

			pkt[0]  = 8'hFF;
			pkt[1]  = 8'hFF;
			pkt[2]  = 8'hFF;
			pkt[3]  = 8'hAF;
			pkt[4]  = 8'h82;
			pkt[5]  = {4'h4, channel};
			pkt[6]  = {rolling_code[3:0], rolling_code[7:4]};
			pkt[7]  = {4'h8, 4'(mag % 10)};
			pkt[8]  = {4'((mag / 10) % 10), 4'(mag / 100)};
			pkt[9]  = {neg, 3'b000, 4'(lv % 10)};
			pkt[10] = {4'(lv / 10), 4'h0};

			sum = {4'h0, pkt[3][3:0]};
			crc = crc_step(8'h00, {4'h0, pkt[3][3:0]});
			for (int i = 4; i <= 10; i++) begin
				sum = sum + pkt[i][3:0] + pkt[i][7:4];
				crc = crc_step(crc, pkt[i]);
			end
			pkt[11] = {sum[3:0], sum[7:4]};
			pkt[12] = {crc[3:0], crc[7:4]};

			for (int i = 0; i < WordsPerPacket; i++) begin
				w.pbyte = pkt[i];
				w.idx   = 4'(i);
				w.chips = chip_pattern(pkt[i]);
				w.last  = (i == WordsPerPacket - 1);
				pending_words.push_back(w);
			end
		endfunction

		function void check_word(logic [7:0] pb, logic [3:0] bi, logic [15:0] ch, logic lst);
			word_t w;
			if (pending_words.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("ERROR: unexpected word byte=%02h idx=%0d chips=%04h last=%0b",
						pb, bi, ch, lst);
				return;
			end
			w = pending_words.pop_front();
			words_checked++;
			if (w.pbyte !== pb || w.idx !== bi || w.chips !== ch || w.last !== lst) begin
				errors++;
				if (errors <= 10)
					$display("ERROR: word %0d exp byte=%02h idx=%0d chips=%04h last=%0b, got byte=%02h idx=%0d chips=%04h last=%0b",
						words_checked, w.pbyte, w.idx, w.chips, w.last, pb, bi, ch, lst);
			end
		endfunction
	endclass

	packet_scoreboard sb = new();

	bit no_idle = 1'b0;   // phases with back-to-back traffic on both sides
	int n_readings = 0;
	int n_writes = 0;

	function automatic int draw_gap();
		return no_idle ? 0 : $urandom_range(0, MaxGap);
	endfunction

	// ------------------------------------------------------------------
	// output side: check every accepted word, stall ready at random
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (out_valid && out_ready)
			sb.check_word(packet_byte, byte_index, chips, last_of_packet);
	end

	// per word: drop ready for a random stall from draw_gap, then hold it until a word goes
	initial begin : rx_side
		int stall;
		forever begin
			stall = draw_gap();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// ------------------------------------------------------------------
	// input side
	// ------------------------------------------------------------------
	// A zero gap keeps valid high straight into the next word, so valid is
	// only ever assigned once per edge.
	task automatic send_reading(input int temp_val, input int lvl_val);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		temp_tenths <= 11'(temp_val);
		level       <= 7'(lvl_val);
		do @(posedge clk); while (!in_ready);
		sb.note_reading(11'(temp_val), 7'(lvl_val));
		n_readings++;
	endtask

	// hold off the sender until the last packet has fully drained
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// registers move only while the block is idle
	task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, data);
		n_writes++;
	endtask

	function automatic int rand_temp();
		// mostly in range, some raw 11-bit codes to hit saturation and every bit
		if ($urandom_range(0, 7) == 0)
			return int'($signed(11'($urandom)));
		return int'($urandom_range(0, 1998)) - 999;
	endfunction

	function automatic int rand_level();
		if ($urandom_range(0, 7) == 0)
			return int'($urandom_range(0, 127));
		return int'($urandom_range(0, 100));
	endfunction

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin : stimulus
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset register values: channel 1, code 0, poly 7
		send_reading(0, 0);
		send_reading(-1024, 127);    // both fields at raw minimum / maximum code
		send_reading(1023, 101);     // saturate high, level just past 100
		send_reading(999, 100);      // level 100: tens nibble A, units 0
		send_reading(-999, 99);
		send_reading(-1, 1);
		send_reading(1, 9);
		drain();

		// channel zero, all-ones code, zero polynomial; spare index ignored
		write_reg(CFG_CHANNEL, 8'h00);
		write_reg(CFG_ROLLING, 8'hFF);
		write_reg(CFG_POLY, 8'h00);
		write_reg(CfgSpare, 8'hFF);
		send_reading(-1000, 10);
		send_reading(1000, 0);
		send_reading(-998, 50);
		send_reading(9, 11);
		send_reading(10, 90);
		send_reading(99, 100);
		send_reading(100, 64);
		drain();

		// channel 15 with junk in the upper bits, all-ones polynomial
		write_reg(CFG_CHANNEL, 8'hFF);
		write_reg(CFG_ROLLING, 8'hA5);
		write_reg(CFG_POLY, 8'hFF);
		write_reg(CfgSpare, 8'h00);
		send_reading(123, 42);
		send_reading(-456, 7);
		send_reading(-100, 120);
		send_reading(512, 63);
		send_reading(-513, 1);
		send_reading(998, 99);

		// random phases, fresh register values each time
		for (int p = 0; p < RandomPhases; p++) begin
			drain();
			write_reg(CFG_CHANNEL, 8'($urandom));
			write_reg(CFG_ROLLING, 8'($urandom));
			write_reg(CFG_POLY, 8'($urandom));
			write_reg(CfgSpare, 8'($urandom));
			no_idle = (p % 4 == 3);
			for (int i = 0; i < PhaseReadings; i++) begin
				// halfway: sender waits for the pipe to empty
				if (i == PhaseReadings / 2)
					drain();
				send_reading(rand_temp(), rand_level());
			end
		end
		no_idle = 1'b0;

		drain();
		repeat (SettleCycles) @(posedge clk);

		$display("Run: %0d readings, %0d words checked, %0d register writes across %0d settings.",
			n_readings, sb.words_checked, n_writes, RandomPhases + 3);
		$display("Saturation, level 100, channel zero, spare index and stalls on both sides exercised.");
		if (sb.errors == 0) begin
			$display("sensor_packet_framer_manchester_top verification clean");
		end else begin
			$display("%0d mismatches", sb.errors);
			$display("sensor_packet_framer_manchester_top verification failed");
		end
		$finish;
	end

	// hard stop well past the slowest legal run
	initial begin : watchdog
		#5_000_000;
		$display("Timeout with %0d words still expected", sb.pending());
		$display("sensor_packet_framer_manchester_top verification failed");
		$finish;
	end

endmodule
